FILE: src/flash_slot_record_store_defines.svh
// ---------------------------------------------------------------------------
// flash slot record store assertion macros
// shared assertion forms for the slot store
// ---------------------------------------------------------------------------
`ifndef FLASH_SLOT_RECORD_STORE_DEFINES_SVH
`define FLASH_SLOT_RECORD_STORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define FSRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// condition that always holds outside reset
`define FSRS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`endif

FILE: src/fsrs_pkg.sv
// ---------------------------------------------------------------------------
// fsrs_pkg
// types and constants of the flash slot record store
// ---------------------------------------------------------------------------
package fsrs_pkg;
	localparam int NUM_SLOTS_DEF    = 64;
	localparam int RECORD_BYTES_DEF = 8;
	localparam int REC_W            = 64;
	localparam int CTRL_W           = 16;
	localparam int SLOT_OUT_W       = 6;
	localparam logic [7:0] VERSION_ERASED = 8'hFF;
	localparam logic [CTRL_W-1:0] CTRL_RESET = 16'hA5A5;
	localparam logic CMD_FIND   = 1'b0;
	localparam logic CMD_COMMIT = 1'b1;

	typedef struct packed {
		logic            command;
		logic [REC_W-1:0] record_in;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic [REC_W-1:0] record_out;
		logic             erased;
		logic             written;
	} rsp_t;
endpackage

FILE: src/fsrs_if.sv
// ---------------------------------------------------------------------------
// fsrs_if
// valid ready channel carrying one payload
// ---------------------------------------------------------------------------
interface fsrs_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/fsrs_slot_cell.sv
// ---------------------------------------------------------------------------
// fsrs_slot_cell
// one slot of the ring; holds a record and passes it to its neighbor
// ---------------------------------------------------------------------------
module fsrs_slot_cell (
	input  logic                     clk,
	input  logic                     shift,
	input  logic [fsrs_pkg::REC_W-1:0] d,
	output logic [fsrs_pkg::REC_W-1:0] q
);
	import fsrs_pkg::*;
	logic [REC_W-1:0] rec_q;
	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= d;
		end
	end
	assign q = rec_q;
endmodule

FILE: src/flash_slot_record_store.sv
// find: one pass over the ring; commit: a scan pass, then a search pass that writes
// the record into the first erased slot after the newest valid one, unless it
// already matches; the sector is erased first when no slot is valid or none is erased
// one command at a time; the next is accepted once the response is taken
// reset: ring is erased by a clearing pass over every slot after arst_n
// ---------------------------------------------------------------------------
// flash_slot_record_store
// append-style record store over a rotating chain of slot cells
// ---------------------------------------------------------------------------
`include "flash_slot_record_store_defines.svh"
module flash_slot_record_store #(
	parameter int NUM_SLOTS    = fsrs_pkg::NUM_SLOTS_DEF,
	parameter int RECORD_BYTES = fsrs_pkg::RECORD_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fsrs_if.sink   req,
	fsrs_if.source rsp,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [fsrs_pkg::CTRL_W-1:0] cfg_data
);
	import fsrs_pkg::*;
	localparam int IW  = $clog2(NUM_SLOTS);
	localparam int CW  = $clog2(NUM_SLOTS + 1);
	localparam int RB  = 8 * RECORD_BYTES;
	localparam logic [REC_W-1:0] MASK = (RB >= REC_W) ? {REC_W{1'b1}}
		: ((REC_W'(1) << RB) - REC_W'(1));

	typedef enum logic [5:0] {
		ST_CLR  = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_SCAN = 6'b000100,
		ST_ERAS = 6'b001000,
		ST_SRCH = 6'b010000,
		ST_RSP  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [CTRL_W-1:0] ctrl_q;
	logic             cmd_q;
	logic [REC_W-1:0] rec_q;
	logic [CW-1:0]    cnt_q;
	logic [IW-1:0]    pos_q;
	logic             found_q, erased_q, written_q, have_q, done_q;
	logic [IW-1:0]    cur_q, slot_q;
	logic [REC_W-1:0] out_rec_q, cur_rec_q;
	logic             rsp_valid_q;

	// head cell 0 is the slot at position pos_q; ring rotates toward lower cells
	logic [REC_W-1:0] cell_q [NUM_SLOTS];
	logic [REC_W-1:0] cell_d [NUM_SLOTS];
	logic             shift;
	logic [REC_W-1:0] head, head_in;
	logic             head_valid, head_erased;

	assign head = cell_q[0];
	assign head_valid = (head[7:0] != VERSION_ERASED)
		&& (head[RB-1 -: CTRL_W] == ctrl_q);
	assign head_erased = ((head & MASK) == MASK);

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		if (i == NUM_SLOTS - 1) begin : g_tail
			assign cell_d[i] = head_in;
		end else begin : g_mid
			assign cell_d[i] = cell_q[i+1];
		end
		fsrs_slot_cell u_cell (.clk(clk), .shift(shift), .d(cell_d[i]), .q(cell_q[i]));
	end

	logic last;
	assign last = (cnt_q == CW'(NUM_SLOTS - 1));
	logic srch_hit;
	assign srch_hit = !done_q && (pos_q >= cur_q) && head_erased;

	always_comb begin
		shift = 1'b0;
		head_in = head;
		unique case (state_q)
			ST_CLR: begin
				shift = 1'b1;
				head_in = MASK;
			end
			ST_SCAN, ST_ERAS: begin
				shift = 1'b1;
				if (state_q == ST_ERAS) head_in = MASK;
			end
			ST_SRCH: begin
				shift = 1'b1;
				if (srch_hit) head_in = rec_q;
			end
			default: shift = 1'b0;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data.found = found_q;
	assign rsp.data.slot_index = SLOT_OUT_W'(32'(slot_q));
	assign rsp.data.record_out = out_rec_q;
	assign rsp.data.erased = erased_q;
	assign rsp.data.written = written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			ctrl_q <= CTRL_RESET;
			cnt_q <= '0;
			pos_q <= '0;
			rsp_valid_q <= 1'b0;
			done_q <= 1'b0;
			have_q <= 1'b0;
		end else begin
			if (shift) pos_q <= (pos_q == IW'(NUM_SLOTS - 1)) ? '0 : pos_q + IW'(1);
			unique case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + CW'(1);
					if (last) begin
						state_q <= ST_IDLE;
						cnt_q <= '0;
					end
				end
				ST_IDLE: begin
					if (cfg_valid) ctrl_q <= cfg_data;
					if (req.valid) begin
						cmd_q <= req.data.command;
						rec_q <= req.data.record_in & MASK;
						have_q <= 1'b0;
						cnt_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// the last valid position seen is the highest one
					if (head_valid) begin
						have_q <= 1'b1;
						cur_q <= pos_q;
						cur_rec_q <= head & MASK;
					end
					cnt_q <= cnt_q + CW'(1);
					if (last) begin
						cnt_q <= '0;
						found_q <= have_q || head_valid;
						erased_q <= 1'b0;
						written_q <= 1'b0;
						out_rec_q <= '0;
						done_q <= 1'b0;
						if (cmd_q == CMD_FIND) begin
							if (head_valid) begin
								slot_q <= pos_q;
								out_rec_q <= head & MASK;
							end else if (have_q) begin
								slot_q <= cur_q;
								out_rec_q <= cur_rec_q;
							end else slot_q <= '0;
							state_q <= ST_RSP;
						end else if (!(have_q || head_valid)) begin
							erased_q <= 1'b1;
							cur_q <= '0;
							slot_q <= '0;
							state_q <= ST_ERAS;
						end else begin
							if (head_valid) begin
								slot_q <= pos_q;
								cur_q <= pos_q;
								if ((head & MASK) == rec_q) state_q <= ST_RSP;
								else state_q <= ST_SRCH;
							end else begin
								slot_q <= cur_q;
								if (cur_rec_q == rec_q) state_q <= ST_RSP;
								else state_q <= ST_SRCH;
							end
						end
					end
				end
				ST_ERAS: begin
					// sector erase; slot 0 is then compared or written
					cnt_q <= cnt_q + CW'(1);
					if (last) begin
						cnt_q <= '0;
						state_q <= (!found_q && rec_q == MASK) ? ST_RSP : ST_SRCH;
					end
				end
				ST_SRCH: begin
					cnt_q <= cnt_q + CW'(1);
					if (srch_hit) begin
						done_q <= 1'b1;
						written_q <= 1'b1;
						slot_q <= pos_q;
					end
					if (last) begin
						cnt_q <= '0;
						if (!done_q && !srch_hit) begin
							// no erased slot: erase then program slot 0
							erased_q <= 1'b1;
							cur_q <= '0;
							state_q <= ST_ERAS;
						end else state_q <= ST_RSP;
					end
				end
				ST_RSP: begin
					rsp_valid_q <= 1'b1;
					if (rsp_valid_q && rsp.ready) begin
						rsp_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FSRS_ASSERT_IMP(a_ready_idle, clk, arst_n, req.ready, !rsp_valid_q)
	`FSRS_ASSERT_IMP(a_rsp_in_rsp, clk, arst_n, rsp_valid_q, state_q == ST_RSP)
	`FSRS_ASSERT_IMP(a_pos_wrap, clk, arst_n, state_q == ST_IDLE, pos_q == '0)
endmodule
